// File: rtl/ctaem_pkg.sv
package ctaem_pkg;

	localparam int MAX_TRIGGERS = 16;
	localparam int IDX_W = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
	localparam int CNT_W = $clog2(MAX_TRIGGERS + 1);
	localparam int MASK_W = 16;
	localparam int SIN_LAT = 5;
	localparam int SEQ_W = 4;

	localparam logic [15:0] MIN_ENERGY_RST = 16'd100;
	localparam logic [15:0] MAX_ANGLE_RST = 16'd1565;
	localparam logic [9:0] MIN_FRAC_RST = 10'd0;
	localparam logic [9:0] MAX_FRAC_RST = 10'd512;
	localparam logic [15:0] QUARTER_TURN = 16'd16384;
	localparam logic [15:0] HALF_TURN = 16'd32768;

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_CLEAR = 2'd1,
		FUNC_QUERY = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_MIN_ENERGY = 2'd0,
		REG_MAX_ANGLE = 2'd1,
		REG_MIN_FRAC = 2'd2,
		REG_MAX_FRAC = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TRIG,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [15:0] energy;
	} entry_t;

	typedef struct packed {
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic signed [17:0] dz;
		logic k_neg;
		logic [30:0] kk;
		logic [15:0] energy;
		logic [9:0] min_frac;
		logic [9:0] max_frac;
		logic ang_none;
		logic ang_all;
	} qry_t;

	typedef struct packed {
		logic vld;
		logic ok;
		logic [IDX_W-1:0] idx;
		logic busy;
	} evres_t;

endpackage

// File: rtl/cluster_trigger_angle_energy_matcher.sv
// Cluster-to-trigger matcher.
// Commands come in on start while busy is low; func selects load, clear or query.
// A load stores one trigger point in the next free cell (dropped when the table
// is full) and a clear empties the table; neither gives a result.
// A query gives exactly one result: valid is high for one cycle with match_mask,
// trigger_flag and matching_done. A query without a usable hypothesis or with
// too little energy answers in the cycle after acceptance and leaves busy low.
// Any other query keeps busy high while it computes the cluster direction and
// the angle limit in a five-stage sine pipeline, then has the cell chain rotate
// its entries past the four-stage evaluation pipeline, one table entry per
// cycle, and then drains that pipeline and publishes. The result shows in the
// same cycle as busy falls. The receiver cannot stall; the result is shown once.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at
// once and are meant for idle periods. Reset empties the table and loads the
// default limits.
module cluster_trigger_angle_energy_matcher import ctaem_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] func,
	input logic signed [15:0] trg_x,
	input logic signed [15:0] trg_y,
	input logic signed [15:0] trg_z,
	input logic [15:0] trg_energy,
	input logic [15:0] cl_theta,
	input logic signed [15:0] cl_phi,
	input logic has_photon,
	input logic [15:0] photon_energy,
	input logic has_hadron,
	input logic [15:0] hadron_energy,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	output logic valid,
	output logic [MASK_W-1:0] match_mask,
	output logic trigger_flag,
	output logic matching_done
);

	state_t state_q, state_d;
	logic [15:0] min_energy_q, max_angle_q;
	logic [9:0] min_frac_q, max_frac_q;
	logic [CNT_W-1:0] count_q, scnt_q;
	logic [SEQ_W-1:0] seq_q;
	logic [15:0] theta_q, phi_q, energy_q;
	logic signed [17:0] st_q, ct_q, cp_q, sp_q, k_q, dx_q, dy_q;
	logic signed [35:0] px_q, py_q, kk_q;
	logic [MASK_W-1:0] mask_q;
	logic any_q, valid_q, done_q;
	logic accept, take_load, early, scan_en, seq_end, scan_end, finish;
	logic [15:0] e_sel, sin_in;
	logic signed [17:0] sine;
	entry_t ld_data;
	entry_t ent [MAX_TRIGGERS];
	qry_t qry;
	evres_t res;

	assign accept = start && !busy;
	assign e_sel = has_photon ? photon_energy : hadron_energy;
	assign early = !(has_photon || has_hadron) || (e_sel < min_energy_q) || (e_sel == 16'd0);
	assign take_load = accept && (func_t'(func) == FUNC_LOAD) && (count_q < CNT_W'(MAX_TRIGGERS));
	assign ld_data = '{x: trg_x, y: trg_y, z: trg_z, energy: trg_energy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		scan_en = 1'b0;
		finish = 1'b0;
		seq_end = (seq_q == SEQ_W'(SIN_LAT + 6));
		scan_end = (scnt_q == CNT_W'(MAX_TRIGGERS - 1));
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (func_t'(func) == FUNC_QUERY) && !early) begin
					state_d = ST_TRIG;
				end
			end
			ST_TRIG: begin
				if (seq_end) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_en = 1'b1;
				if (scan_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!res.busy) begin
					finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_energy_q <= MIN_ENERGY_RST;
			max_angle_q <= MAX_ANGLE_RST;
			min_frac_q <= MIN_FRAC_RST;
			max_frac_q <= MAX_FRAC_RST;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_MIN_ENERGY: min_energy_q <= cfg_data;
					REG_MAX_ANGLE: max_angle_q <= cfg_data;
					REG_MIN_FRAC: min_frac_q <= cfg_data[9:0];
					REG_MAX_FRAC: max_frac_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (take_load) begin
				count_q <= count_q + CNT_W'(1);
			end else if (accept && (func_t'(func) == FUNC_CLEAR)) begin
				count_q <= '0;
			end
			valid_q <= finish || (accept && (func_t'(func) == FUNC_QUERY) && early);
		end
	end

	// Sine pipeline is fed sin(theta), cos(theta), cos(phi), sin(phi) and
	// cos(max_angle) on consecutive cycles.
	always_comb begin
		unique case (seq_q)
			SEQ_W'(0): sin_in = theta_q;
			SEQ_W'(1): sin_in = theta_q + QUARTER_TURN;
			SEQ_W'(2): sin_in = phi_q + QUARTER_TURN;
			SEQ_W'(3): sin_in = phi_q;
			SEQ_W'(4): sin_in = max_angle_q + QUARTER_TURN;
			default: sin_in = 16'd0;
		endcase
	end

	ctaem_sin u_sin (
		.clk(clk),
		.angle(sin_in),
		.sine(sine)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			theta_q <= cl_theta;
			phi_q <= cl_phi;
			energy_q <= e_sel;
			seq_q <= '0;
		end else if (state_q == ST_TRIG) begin
			seq_q <= seq_q + SEQ_W'(1);
		end
		unique case (seq_q)
			SEQ_W'(SIN_LAT): st_q <= sine;
			SEQ_W'(SIN_LAT + 1): ct_q <= sine;
			SEQ_W'(SIN_LAT + 2): cp_q <= sine;
			SEQ_W'(SIN_LAT + 3): sp_q <= sine;
			SEQ_W'(SIN_LAT + 4): k_q <= sine;
			default: ;
		endcase
		if (seq_q == SEQ_W'(SIN_LAT + 5)) begin
			px_q <= 36'(st_q) * 36'(cp_q);
			py_q <= 36'(st_q) * 36'(sp_q);
			kk_q <= 36'(k_q) * 36'(k_q);
		end
		if (seq_q == SEQ_W'(SIN_LAT + 6)) begin
			// Truncating division by 32768: round negative products toward zero.
			dx_q <= 18'((px_q + (px_q[35] ? 36'sd32767 : 36'sd0)) >>> 15);
			dy_q <= 18'((py_q + (py_q[35] ? 36'sd32767 : 36'sd0)) >>> 15);
		end
		if (state_q == ST_TRIG) begin
			scnt_q <= '0;
			mask_q <= '0;
			any_q <= 1'b0;
		end else begin
			if (scan_en) begin
				scnt_q <= scnt_q + CNT_W'(1);
			end
			if (res.vld && res.ok && (CNT_W'(res.idx) < count_q)) begin
				any_q <= 1'b1;
				if (int'(res.idx) < MASK_W) begin
					mask_q[res.idx] <= 1'b1;
				end
			end
		end
		if (finish) begin
			match_mask <= mask_q;
			trigger_flag <= any_q;
			done_q <= 1'b1;
		end else if (accept && (func_t'(func) == FUNC_QUERY)) begin
			match_mask <= '0;
			trigger_flag <= 1'b0;
			done_q <= has_photon || has_hadron;
		end
	end

	assign valid = valid_q;
	assign matching_done = done_q;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_TRIGGERS; gi++) begin : g_cell
			ctaem_cell u_cell (
				.clk(clk),
				.ld(take_load && (count_q[IDX_W-1:0] == IDX_W'(gi))),
				.ld_data(ld_data),
				.shift(scan_en),
				.nxt(ent[(gi + 1) % MAX_TRIGGERS]),
				.q(ent[gi])
			);
		end
	endgenerate

	assign qry.dx = dx_q;
	assign qry.dy = dy_q;
	assign qry.dz = ct_q;
	assign qry.k_neg = k_q[17];
	assign qry.kk = kk_q[30:0];
	assign qry.energy = energy_q;
	assign qry.min_frac = min_frac_q;
	assign qry.max_frac = max_frac_q;
	assign qry.ang_none = (max_angle_q == 16'd0);
	assign qry.ang_all = (max_angle_q > HALF_TURN);

	ctaem_eval u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.vld(scan_en),
		.idx(scnt_q[IDX_W-1:0]),
		.entry(ent[0]),
		.qry(qry),
		.res(res)
	);

`ifndef NO_ASSERTIONS
	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !busy) else $error("result shown while a query is still running");
	a_flag_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid && trigger_flag |-> matching_done) else $error("match without processing");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TRIGGERS)) else $error("trigger count overflow");
	a_query: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FUNC_QUERY) |=> valid || busy)
		else $error("query transaction lost");
`endif

endmodule

// File: rtl/ctaem_sin.sv
module ctaem_sin import ctaem_pkg::*; (
	input logic clk,
	input logic [15:0] angle,
	output logic signed [17:0] sine
);

	logic [14:0] r;
	logic [15:0] z_s1, z_s2, z_s3, z_s4;
	logic n_s1, n_s2, n_s3, n_s4;
	logic [15:0] z2_s2, z2_s3;
	logic [14:0] t1_s3;
	logic [15:0] t2_s4;
	logic signed [17:0] s_s5;
	logic [31:0] zz;
	logic [26:0] pt1;
	logic [30:0] pt2;
	logic [31:0] ps;

	// Odd quadrants run the polynomial on the mirrored angle.
	assign r = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
	assign zz = 32'(z_s1) * 32'(z_s1);
	assign pt1 = 27'd2320 * 27'(z2_s2);
	assign pt2 = 31'(z2_s3) * 31'(t1_s3);
	assign ps = 32'(z_s4) * 32'(t2_s4);

	always_ff @(posedge clk) begin
		z_s1 <= {r, 1'b0};
		n_s1 <= angle[15];
		z2_s2 <= zz[30:15];
		z_s2 <= z_s1;
		n_s2 <= n_s1;
		t1_s3 <= 15'd21024 - 15'(pt1[26:15]);
		z2_s3 <= z2_s2;
		z_s3 <= z_s2;
		n_s3 <= n_s2;
		t2_s4 <= 16'd51472 - 16'(pt2[30:15]);
		z_s4 <= z_s3;
		n_s4 <= n_s3;
		s_s5 <= n_s4 ? -$signed({1'b0, ps[31:15]}) : $signed({1'b0, ps[31:15]});
	end

	assign sine = s_s5;

endmodule

// File: rtl/ctaem_cell.sv
module ctaem_cell import ctaem_pkg::*; (
	input logic clk,
	input logic ld,
	input entry_t ld_data,
	input logic shift,
	input entry_t nxt,
	output entry_t q
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ld) begin
			entry_q <= ld_data;
		end else if (shift) begin
			entry_q <= nxt;
		end
	end

	assign q = entry_q;

endmodule

// File: rtl/ctaem_eval.sv
module ctaem_eval import ctaem_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic vld,
	input logic [IDX_W-1:0] idx,
	input entry_t entry,
	input qry_t qry,
	output evres_t res
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0] i_s1, i_s2, i_s3, i_s4;
	logic signed [33:0] px_s1, py_s1, pz_s1;
	logic [30:0] nx_s1, ny_s1, nz_s1;
	logic [25:0] elo_s1, ehi_s1;
	logic [23:0] t_s1;
	logic signed [34:0] d_s2;
	logic [31:0] n2_s2;
	logic eok_s2, eok_s3, eok_s4;
	logic [31:0] hh_s3, hl_s3, ll_s3;
	logic [46:0] nkh_s3, nkl_s3;
	logic dpos_s3, dnn_s3, nz_s3, dpos_s4, dnn_s4, nz_s4;
	logic [63:0] d2_s4, rhs_s4;
	logic signed [31:0] sx, sy, sz;
	logic [34:0] ad;
	logic ang;

	assign sx = 32'(entry.x) * 32'(entry.x);
	assign sy = 32'(entry.y) * 32'(entry.y);
	assign sz = 32'(entry.z) * 32'(entry.z);
	assign ad = d_s2[34] ? 35'(-d_s2) : 35'(d_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		i_s1 <= idx;
		px_s1 <= 34'(qry.dx) * 34'(entry.x);
		py_s1 <= 34'(qry.dy) * 34'(entry.y);
		pz_s1 <= 34'(qry.dz) * 34'(entry.z);
		nx_s1 <= sx[30:0];
		ny_s1 <= sy[30:0];
		nz_s1 <= sz[30:0];
		elo_s1 <= 26'(qry.min_frac) * 26'(qry.energy);
		ehi_s1 <= 26'(qry.max_frac) * 26'(qry.energy);
		t_s1 <= {entry.energy, 8'd0};

		i_s2 <= i_s1;
		d_s2 <= 35'(px_s1) + 35'(py_s1) + 35'(pz_s1);
		n2_s2 <= 32'(nx_s1) + 32'(ny_s1) + 32'(nz_s1);
		eok_s2 <= (26'(t_s1) > elo_s1) && (26'(t_s1) < ehi_s1);

		// The squared dot product is built from 16-bit halves of its magnitude.
		i_s3 <= i_s2;
		hh_s3 <= 32'(ad[31:16]) * 32'(ad[31:16]);
		hl_s3 <= 32'(ad[31:16]) * 32'(ad[15:0]);
		ll_s3 <= 32'(ad[15:0]) * 32'(ad[15:0]);
		nkh_s3 <= 47'(n2_s2[31:16]) * 47'(qry.kk);
		nkl_s3 <= 47'(n2_s2[15:0]) * 47'(qry.kk);
		dpos_s3 <= !d_s2[34] && (d_s2 != 35'sd0);
		dnn_s3 <= !d_s2[34];
		nz_s3 <= (n2_s2 == 32'd0);
		eok_s3 <= eok_s2;

		i_s4 <= i_s3;
		d2_s4 <= {hh_s3, 32'd0} + {15'd0, hl_s3, 17'd0} + {32'd0, ll_s3};
		rhs_s4 <= {1'b0, nkh_s3, 16'd0} + {17'd0, nkl_s3};
		dpos_s4 <= dpos_s3;
		dnn_s4 <= dnn_s3;
		nz_s4 <= nz_s3;
		eok_s4 <= eok_s3;
	end

	always_comb begin
		if (qry.ang_none) begin
			ang = 1'b0;
		end else if (qry.ang_all || nz_s4) begin
			ang = 1'b1;
		end else if (!qry.k_neg) begin
			ang = dpos_s4 && (d2_s4 > rhs_s4);
		end else begin
			ang = dnn_s4 || (d2_s4 < rhs_s4);
		end
	end

	assign res.vld = v_s4;
	assign res.ok = eok_s4 && ang;
	assign res.idx = i_s4;
	assign res.busy = v_s1 || v_s2 || v_s3 || v_s4;

endmodule
